[hw/rtl/isr_pkg.sv]
package isr_pkg;

    localparam int DATA_W        = 32;
    localparam int CMP_W         = 12;
    localparam int MOV_W         = 6;
    localparam int DEPTH_DEFAULT = 64;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     final_res;
        logic [CMP_W-1:0]         comparisons;
        logic [MOV_W-1:0]         moves;
        logic                     overflow;
    } out_t;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;
        logic drain;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_DRAIN = 2'b10
    } state_t;

endpackage

[hw/rtl/isr_cell.sv]
module isr_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 7
) (
    input  logic                              aclk,
    input  isr_pkg::cell_ctrl_t               ctrl,
    input  logic [CNT_W-1:0]                  count,
    input  logic signed [isr_pkg::DATA_W-1:0] v,
    input  logic                              lower_gt,
    input  logic signed [isr_pkg::DATA_W-1:0] lower_val,
    input  logic signed [isr_pkg::DATA_W-1:0] upper_val,
    output logic                              gt,
    output logic signed [isr_pkg::DATA_W-1:0] val
);

    logic signed [isr_pkg::DATA_W-1:0] val_reg;
    logic                              occ;
    logic                              first_empty;

    assign occ         = CNT_W'(IDX) < count;
    assign first_empty = count == CNT_W'(IDX);
    assign gt          = occ && (val_reg > v);
    assign val         = val_reg;

    // A cell holding a greater value takes its lower neighbor's value, or the new
    // value when it sits at the insertion point. Draining moves values down.
    always_ff @(posedge aclk) begin
        if (ctrl.insert && (gt || first_empty)) begin
            val_reg <= lower_gt ? lower_val : v;
        end else if (ctrl.drain) begin
            val_reg <= upper_val;
        end
    end

endmodule

[hw/rtl/insertion_sorter_with_counts_core.sv]
// Insertion sorter with sort statistics.
// Input channel s_valid/s_ready/s_payload carries one signed value per transfer,
// with a last flag closing the set. Each value is inserted into a chain of
// STORE_DEPTH compare-and-shift cells in the cycle it is accepted, so input
// items are taken one per cycle. Values arriving while the chain is full are
// dropped and the overflow flag is raised for the set.
// After the transfer marked last, the block stops accepting input, waits for
// the shift tally to settle and then drains the chain through the output
// register m_valid/m_ready/m_payload, one result per cycle in ascending order.
// The first result is loaded once the tally of the last insertion has been
// added, or without that wait when the last value was dropped.
// Every result carries the comparison count, the move count and the overflow
// flag; final_res marks the greatest element. A stalled receiver holds the
// output register and the chain in place. Input is accepted again once the
// last result of the set is loaded into the output register.
// Reset (aresetn low, synchronous) empties the chain and clears all counters.
module insertion_sorter_with_counts_core #(
    parameter int STORE_DEPTH = isr_pkg::DEPTH_DEFAULT
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  isr_pkg::in_t  s_payload,
    output logic          m_valid,
    input  logic          m_ready,
    output isr_pkg::out_t m_payload
);

    localparam int CNT_W = $clog2(STORE_DEPTH + 1);

    isr_pkg::state_t       state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      rem_reg, rem_next;
    logic [isr_pkg::CMP_W-1:0] tally_reg, tally_next;
    logic                  dropped_reg, dropped_next;
    logic [CNT_W-1:0]      shift_cnt_reg, shift_cnt_next;
    logic                  shift_pend_reg, shift_pend_next;
    logic                  m_valid_reg, m_valid_next;
    isr_pkg::out_t         out_reg, out_next;

    isr_pkg::cell_ctrl_t   ctrl;
    logic                  accept;
    logic                  do_insert;
    logic                  load;
    logic [STORE_DEPTH-1:0] gt_w;
    logic [STORE_DEPTH-1:0] bound_w;
    logic signed [isr_pkg::DATA_W-1:0] val_w [STORE_DEPTH];
    logic [CNT_W-1:0]      enc;
    logic [CNT_W-1:0]      pos;

    assign s_ready   = state_reg == isr_pkg::ST_IDLE;
    assign accept    = s_valid && s_ready;
    assign do_insert = accept && (count_reg < CNT_W'(STORE_DEPTH));
    assign load      = (state_reg == isr_pkg::ST_DRAIN) && !shift_pend_reg
                       && (!m_valid_reg || m_ready);

    assign ctrl.insert = do_insert;
    assign ctrl.drain  = load;

    genvar gi;
    generate
        for (gi = 0; gi < STORE_DEPTH; gi++) begin : g_cell
            logic                              lower_gt;
            logic signed [isr_pkg::DATA_W-1:0] lower_val;
            logic signed [isr_pkg::DATA_W-1:0] upper_val;

            if (gi == 0) begin : g_bottom
                assign lower_gt   = 1'b0;
                assign lower_val  = '0;
                assign bound_w[gi] = gt_w[gi];
            end else begin : g_mid
                assign lower_gt   = gt_w[gi-1];
                assign lower_val  = val_w[gi-1];
                assign bound_w[gi] = gt_w[gi] && !gt_w[gi-1];
            end

            if (gi == STORE_DEPTH - 1) begin : g_top
                assign upper_val = '0;
            end else begin : g_below
                assign upper_val = val_w[gi+1];
            end

            isr_cell #(
                .IDX   (gi),
                .CNT_W (CNT_W)
            ) u_cell (
                .aclk      (aclk),
                .ctrl      (ctrl),
                .count     (count_reg),
                .v         (s_payload.value),
                .lower_gt  (lower_gt),
                .lower_val (lower_val),
                .upper_val (upper_val),
                .gt        (gt_w[gi]),
                .val       (val_w[gi])
            );
        end
    endgenerate

    // The greater cells form a contiguous run at the top of the occupied part,
    // so the number of shifts is the count minus the position where the run starts.
    always_comb begin
        enc = '0;
        for (int i = 0; i < STORE_DEPTH; i++) begin
            enc = enc | (bound_w[i] ? CNT_W'(i) : '0);
        end
        pos = (|bound_w) ? enc : count_reg;
    end

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        rem_next        = rem_reg;
        tally_next      = tally_reg;
        dropped_next    = dropped_reg;
        shift_cnt_next  = shift_cnt_reg;
        shift_pend_next = 1'b0;
        m_valid_next    = m_valid_reg;
        out_next        = out_reg;

        if (shift_pend_reg) begin
            tally_next = tally_reg + isr_pkg::CMP_W'({shift_cnt_reg, 1'b0});
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            isr_pkg::ST_IDLE: begin
                if (accept) begin
                    if (do_insert) begin
                        count_next      = count_reg + 1'b1;
                        shift_cnt_next  = count_reg - pos;
                        shift_pend_next = 1'b1;
                    end else begin
                        dropped_next = 1'b1;
                    end
                    if (s_payload.last) begin
                        state_next = isr_pkg::ST_DRAIN;
                        rem_next   = do_insert ? count_reg + 1'b1 : count_reg;
                    end
                end
            end
            isr_pkg::ST_DRAIN: begin
                if (load) begin
                    m_valid_next          = 1'b1;
                    out_next.sorted_value = val_w[0];
                    out_next.final_res    = rem_reg == CNT_W'(1);
                    out_next.comparisons  = tally_reg;
                    out_next.moves        = isr_pkg::MOV_W'(count_reg - 1'b1);
                    out_next.overflow     = dropped_reg;
                    rem_next              = rem_reg - 1'b1;
                    if (rem_reg == CNT_W'(1)) begin
                        state_next   = isr_pkg::ST_IDLE;
                        count_next   = '0;
                        tally_next   = '0;
                        dropped_next = 1'b0;
                    end
                end
            end
            default: begin
                state_next = isr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= isr_pkg::ST_IDLE;
            count_reg      <= '0;
            rem_reg        <= '0;
            tally_reg      <= '0;
            dropped_reg    <= 1'b0;
            shift_pend_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            rem_reg        <= rem_next;
            tally_reg      <= tally_next;
            dropped_reg    <= dropped_next;
            shift_pend_reg <= shift_pend_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_cnt_reg <= shift_cnt_next;
        out_reg       <= out_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

endmodule

[hw/rtl/isr_checker.sv]
module isr_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input isr_pkg::in_t  s_payload,
    input logic          m_valid,
    input logic          m_ready,
    input isr_pkg::out_t m_payload
);

    // A stalled result holds its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("stalled result changed");

    // While a set is being emitted, no input transfer is taken.
    a_no_input_mid_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_payload.final_res |-> !s_ready)
        else $error("input ready in the middle of a set");

    // Statistics are the same for every result of one set.
    a_stats_const: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_payload.final_res |=>
            m_valid && $stable(m_payload.comparisons) && $stable(m_payload.moves)
            && $stable(m_payload.overflow))
        else $error("statistics changed within a set");

    // Results of one set come out in ascending order.
    a_ascending: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_payload.final_res |=>
            $signed(m_payload.sorted_value) >= $signed($past(m_payload.sorted_value)))
        else $error("results out of order");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    logic unused_in;
    assign unused_in = s_valid ^ (^s_payload);

endmodule

bind insertion_sorter_with_counts_core isr_checker u_isr_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_payload (s_payload),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);

[tb/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DATA_W      = isr_pkg::DATA_W;
    localparam int CMP_W       = isr_pkg::CMP_W;
    localparam int MOV_W       = isr_pkg::MOV_W;
    localparam int DEPTH       = isr_pkg::DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TALLY_MAX   = (1 << CMP_W) - 1;
    localparam int DRAIN_TAIL  = 10;

    logic          aclk      = 1'b0;
    logic          aresetn   = 1'b0;
    logic          s_valid   = 1'b0;
    logic          s_ready;
    isr_pkg::in_t  s_payload = '0;
    logic          m_valid;
    logic          m_ready   = 1'b0;
    isr_pkg::out_t m_payload;

    // Shadow copy of the sorter state.
    logic signed [DATA_W-1:0] shadow_store [DEPTH];
    int                       shadow_fill    = 0;
    int                       shadow_tally   = 0;
    logic                     shadow_dropped = 1'b0;

    isr_pkg::out_t sorted_expect [$];
    int   mismatch_count = 0;
    int   items_accepted = 0;
    int   cycle_count    = 0;
    bit   idle_enable    = 1'b1;

    insertion_sorter_with_counts_core #(
        .STORE_DEPTH(DEPTH)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Inserts an accepted value into the shadow store (flags a drop when full)
    // and, on the closing value of a set, queues the whole ascending sequence.
    function automatic void sort_predict(isr_pkg::in_t item);
        int            pos;
        isr_pkg::out_t res;
        if (shadow_fill < DEPTH) begin
            pos = shadow_fill;
            while (pos > 0 && $signed(shadow_store[pos-1]) > $signed(item.value)) begin
                shadow_store[pos] = shadow_store[pos-1];
                shadow_tally = shadow_tally + 2;
                if (shadow_tally > TALLY_MAX) begin
                    shadow_tally = TALLY_MAX;
                end
                pos--;
            end
            shadow_store[pos] = item.value;
            shadow_fill++;
        end else begin
            shadow_dropped = 1'b1;
        end
        if (item.last) begin
            for (int k = 0; k < shadow_fill; k++) begin
                res.sorted_value = shadow_store[k];
                res.final_res    = (k == shadow_fill - 1);
                res.comparisons  = CMP_W'(shadow_tally);
                res.moves        = MOV_W'(shadow_fill - 1);
                res.overflow     = shadow_dropped;
                sorted_expect.push_back(res);
            end
            shadow_fill    = 0;
            shadow_tally   = 0;
            shadow_dropped = 1'b0;
        end
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want_val);
        $display("mismatch in %s: got %0h, expected %0h (cycle %0d)",
                 field, got, want_val, cycle_count);
        mismatch_count++;
    endtask

    // Valid is only lowered when a gap follows, so it never drops and rises
    // again within one time step.
    task automatic send_item(logic signed [DATA_W-1:0] value, logic last);
        int           gap;
        isr_pkg::in_t item;
        item.value = value;
        item.last  = last;
        gap = idle_enable ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= item;
        do @(posedge aclk); while (!s_ready);
        sort_predict(item);
        items_accepted++;
    endtask

    task automatic wait_for_results;
        s_valid <= 1'b0;
        do @(posedge aclk); while (sorted_expect.size() != 0);
    endtask

    function automatic logic signed [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0: return {1'b1, {(DATA_W-1){1'b0}}};
            1: return {1'b0, {(DATA_W-1){1'b1}}};
            2, 3: return DATA_W'($signed($urandom_range(0, 8)) - 4);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_single_values;
        send_item({1'b1, {(DATA_W-1){1'b0}}}, 1'b1);
        send_item({1'b0, {(DATA_W-1){1'b1}}}, 1'b1);
        send_item('0, 1'b1);
        send_item('1, 1'b1);
    endtask

    task automatic test_extremes_and_equals;
        // Equal values keep arrival order and add no comparisons.
        send_item(32'sd5, 1'b0);
        send_item({1'b0, {(DATA_W-1){1'b1}}}, 1'b0);
        send_item(32'sd5, 1'b0);
        send_item({1'b1, {(DATA_W-1){1'b0}}}, 1'b0);
        send_item(-32'sd1, 1'b0);
        send_item(32'sd5, 1'b0);
        send_item('0, 1'b0);
        send_item({1'b0, {(DATA_W-1){1'b1}}}, 1'b1);
    endtask

    task automatic test_reverse_order;
        for (int i = 0; i < 6; i++) begin
            send_item(DATA_W'(100 - 10 * i), i == 5);
        end
    endtask

    task automatic test_full_store;
        for (int i = 0; i < DEPTH; i++) begin
            send_item(DATA_W'(i - 32), i == DEPTH - 1);
        end
    endtask

    // Descending fill gives the largest tally; the extra values, the closing
    // one included, are dropped.
    task automatic test_overflow;
        for (int i = 0; i < DEPTH + 6; i++) begin
            send_item(DATA_W'(1000 - i), i == DEPTH + 5);
        end
    endtask

    task automatic test_pressure;
        for (int i = 0; i < 4; i++) begin
            send_item(rand_value(), i == 3);
        end
        wait_for_results();
        for (int i = 0; i < 3; i++) begin
            send_item(rand_value(), i == 2);
        end
    endtask

    task automatic test_random_sets(int item_goal);
        int start;
        int set_len;
        start = items_accepted;
        while (items_accepted - start < item_goal) begin
            idle_enable = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 19))
                0:       set_len = $urandom_range(DEPTH - 4, DEPTH + 6);
                1, 2, 3: set_len = 1;
                default: set_len = $urandom_range(2, 12);
            endcase
            for (int i = 0; i < set_len; i++) begin
                send_item(rand_value(), i == set_len - 1);
            end
            if ($urandom_range(0, 7) == 0) begin
                wait_for_results();
            end
        end
        idle_enable = 1'b1;
    endtask

    // Receiver side: random stalls between transfers.
    initial begin
        int stall;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            stall = idle_enable ? $urandom_range(0, 19) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin
        isr_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (sorted_expect.size() == 0) begin
                report_mismatch("unexpected result", m_payload.sorted_value, '0);
            end else begin
                want = sorted_expect.pop_front();
                if (m_payload.sorted_value !== want.sorted_value)
                    report_mismatch("sorted_value", m_payload.sorted_value, want.sorted_value);
                if (m_payload.final_res !== want.final_res)
                    report_mismatch("final_res", m_payload.final_res, want.final_res);
                if (m_payload.comparisons !== want.comparisons)
                    report_mismatch("comparisons", m_payload.comparisons, want.comparisons);
                if (m_payload.moves !== want.moves)
                    report_mismatch("moves", m_payload.moves, want.moves);
                if (m_payload.overflow !== want.overflow)
                    report_mismatch("overflow", m_payload.overflow, want.overflow);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_single_values();
        test_extremes_and_equals();
        test_reverse_order();
        test_full_store();
        test_overflow();
        test_pressure();
        test_random_sets(340);

        s_valid <= 1'b0;
        while (sorted_expect.size() != 0) @(posedge aclk);
        repeat (DRAIN_TAIL) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/isr_pkg.sv
hw/rtl/isr_cell.sv
hw/rtl/insertion_sorter_with_counts_core.sv
hw/rtl/isr_checker.sv
tb/tb.sv
